// ----- hdl/mrfp_pkg.sv -----
// Package with shared constants and types for the modular root block.
`timescale 1ns / 1ps
package mrfp_pkg;
    localparam int PRIME_BITS = 32;
    localparam logic [31:0] P_MASK = (PRIME_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << PRIME_BITS) - 64'd1);
    localparam int XW = 34;

    typedef struct packed {
        logic        start;
        logic        short_mode;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

// ----- hdl/mrfp_div.sv -----
// Bit-serial restoring divider shared by all reductions and quotients.
`timescale 1ns / 1ps
module mrfp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrfp_pkg::t_div_req i_req,
    output mrfp_pkg::t_div_rsp o_rsp
);
    import mrfp_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_dvs;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.short_mode ? 7'd32 : 7'd64;
                r_rem  <= '0;
                r_quo  <= i_req.short_mode ? {i_req.dividend[31:0], 32'd0} : i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? 32'(trial - {1'b0, r_dvs}) : trial[31:0];
                r_quo <= {r_quo[62:0], ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

// ----- hdl/modular_root_from_pair.sv -----
// Top level of the modular root block: computes a / b mod p with a projective flag.
`timescale 1ns / 1ps
// The input channel carries a signed 64-bit numerator, an unsigned 64-bit
// denominator and a 32-bit modulus. A transfer happens when i_valid is high
// and o_stall is low. The block then works on that item alone and holds
// o_stall high until its result has been transferred on the output channel.
// The result is the root a/b mod p with o_projective low, or p itself with
// o_projective high when b has no inverse mod p or p is below two.
// One shared bit-serial divider does every division. It first reduces b mod p.
// Each round of the extended Euclid loop is a check, a quotient step on the
// divider and a bookkeeping step, until the remainder is zero. After the
// final check the divider reduces a, and after a start step it reduces the
// product of a and the inverse. A b that reduces to zero gives its projective
// result at the first check; a modulus below two is answered from idle without
// the divider.
// The result waits in the output register while i_stall is high.
// Reset clears the sequencer and drops o_valid; no item is in flight after it.
module modular_root_from_pair (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_num_a,
    input  logic [63:0] i_den_b,
    input  logic [31:0] i_modulus,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_root,
    output logic        o_projective
);
    import mrfp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_BRED  = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_EDIV  = 8'b0000_1000,
        S_EMUL  = 8'b0001_0000,
        S_ARED  = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_FRED  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    logic               r_out;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic [31:0]        r_p;
    logic [31:0]        r_r0;
    logic [31:0]        r_r1;
    logic signed [XW-1:0] r_x0;
    logic signed [XW-1:0] r_x1;
    logic [31:0]        r_q;
    logic [31:0]        r_inv;
    logic [31:0]        r_am;
    logic [31:0]        r_root;
    logic               r_proj;
    t_div_req           req;
    t_div_rsp           rsp;
    logic [31:0]        pm;
    logic [63:0]        amag;
    logic signed [66:0] qx;
    logic [31:0]        inv_c;

    assign pm    = i_modulus & P_MASK;
    assign amag  = r_a[63] ? (~r_a + 64'd1) : r_a;
    assign qx    = $signed({1'b0, r_q}) * r_x1;
    assign inv_c = r_x0[XW-1] ? 32'(r_x0[31:0] + r_p) : r_x0[31:0];

    always_comb begin
        req = '0;
        req.divisor = r_p;
        unique case (r_state)
            S_IDLE: begin
                req.start    = i_valid && !r_out && (pm >= 32'd2);
                req.dividend = i_den_b;
                req.divisor  = pm;
            end
            S_CHK: begin
                req.start      = 1'b1;
                req.short_mode = (r_r1 != 32'd0);
                req.dividend   = (r_r1 != 32'd0) ? {32'd0, r_r0} : amag;
                req.divisor    = (r_r1 != 32'd0) ? r_r1 : r_p;
                if (r_r1 == 32'd0 && r_r0 != 32'd1) begin
                    req.start = 1'b0;
                end
            end
            S_MUL: begin
                req.start    = 1'b1;
                req.dividend = r_am * r_inv;
            end
            default: begin
                req.dividend = '0;
            end
        endcase
    end

    mrfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out) begin
                        if (!i_stall) begin
                            r_out <= 1'b0;
                        end
                    end else if (i_valid) begin
                        r_a <= i_num_a;
                        r_b <= i_den_b;
                        r_p <= pm;
                        if (pm < 32'd2) begin
                            r_root <= pm;
                            r_proj <= 1'b1;
                            r_out  <= 1'b1;
                        end else begin
                            r_state <= S_BRED;
                        end
                    end
                end
                S_BRED: begin
                    if (rsp.done) begin
                        r_r0    <= r_p;
                        r_r1    <= rsp.rem;
                        r_x0    <= '0;
                        r_x1    <= XW'(1);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_r1 != 32'd0) begin
                        r_state <= S_EDIV;
                    end else if (r_r0 != 32'd1) begin
                        r_root  <= r_p;
                        r_proj  <= 1'b1;
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_inv   <= inv_c;
                        r_state <= S_ARED;
                    end
                end
                S_EDIV: begin
                    if (rsp.done) begin
                        r_q     <= rsp.quo[31:0];
                        r_b     <= {32'd0, rsp.rem};
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    r_r0    <= r_r1;
                    r_r1    <= r_b[31:0];
                    r_x0    <= r_x1;
                    r_x1    <= r_x0 - qx[XW-1:0];
                    r_state <= S_CHK;
                end
                S_ARED: begin
                    if (rsp.done) begin
                        r_am    <= (r_a[63] && rsp.rem != 32'd0) ? (r_p - rsp.rem) : rsp.rem;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FRED;
                end
                S_FRED: begin
                    if (rsp.done) begin
                        r_root  <= rsp.rem;
                        r_proj  <= 1'b0;
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE) || r_out;
    assign o_valid      = r_out;
    assign o_root       = r_root;
    assign o_projective = r_proj;
endmodule

// ----- hdl/mrfp_checker.sv -----
// Port-level checker for the modular root block and its bind statement.
`timescale 1ns / 1ps
module mrfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_root,
    input logic        o_projective
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_root) && $stable(o_projective)))
        else $error("result changed while stalled");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("ready right after a transfer");
    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result waits");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid result after reset");
endmodule

bind modular_root_from_pair mrfp_checker u_mrfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_root       (o_root),
    .o_projective (o_projective)
);
